// ----- hw/rtl/tsgl_pkg.sv -----
package tsgl_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_CELL_W   = 3'd2,
    REG_CELL_H   = 3'd3,
    REG_INV_W    = 3'd4,
    REG_INV_H    = 3'd5,
    REG_COLS     = 3'd6,
    REG_ROWS     = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_BOX,
    ST_SCALE,
    ST_SCAN_SETUP,
    ST_MID,
    ST_EDGE,
    ST_TEST,
    ST_Q_SCALE,
    ST_Q_READ,
    ST_Q_DATA,
    ST_OUT
  } state_t;

  localparam int COORD_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_SEC_W = 6;
  localparam int OUT_CNT_W = 13;
  localparam int OUT_ID_W = 16;
  localparam int IN_ID_W = 16;

endpackage

// ----- hw/rtl/tsgl_if.sv -----
interface tsgl_in_if;
  import tsgl_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic signed [COORD_W-1:0] vert_a_x;
  logic signed [COORD_W-1:0] vert_a_y;
  logic signed [COORD_W-1:0] vert_b_x;
  logic signed [COORD_W-1:0] vert_b_y;
  logic signed [COORD_W-1:0] vert_c_x;
  logic signed [COORD_W-1:0] vert_c_y;
  logic [IN_ID_W-1:0] triangle_id;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  modport source (output valid, mode, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x,
                  vert_c_y, triangle_id, point_x, point_y, input ready);
  modport sink (input valid, mode, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x,
                vert_c_y, triangle_id, point_x, point_y, output ready);
endinterface

interface tsgl_out_if;
  import tsgl_pkg::*;
  logic valid;
  logic ready;
  logic hit_valid;
  logic [OUT_ID_W-1:0] found_id;
  logic [OUT_SEC_W-1:0] sector_col;
  logic [OUT_SEC_W-1:0] sector_row;
  logic [OUT_CNT_W-1:0] cells_written;
  modport source (output valid, hit_valid, found_id, sector_col, sector_row, cells_written,
                  input ready);
  modport sink (input valid, hit_valid, found_id, sector_col, sector_row, cells_written,
                output ready);
endinterface

interface tsgl_cfg_if;
  import tsgl_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/tsgl_ram.sv -----
module tsgl_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/triangle_sector_grid_locator_top.sv -----
// Triangle sector grid locator.
// Three valid/ready channels: in_ carries one command transaction (clear, insert
// or query), out_ returns exactly one result transaction per command, and cfg_
// writes the grid geometry registers. The user is to write them only while the block is
// idle; the block itself does not enforce this. The grid lives in one synchronous RAM
// of MAX_ROWS*MAX_COLS entries, each a valid bit and a triangle identifier.
// After reset the block runs a clearing pass over all MAX_ROWS*MAX_COLS RAM entries
// (4096 by default), one RAM entry per cycle, before it accepts a command.
// Clear zeroes the entries of the configured rows*cols grid, then returns its result.
// Query steps through scale, RAM address, RAM read and output. Insert runs the setup
// steps box, scale and scan bounds, then for each sector in the clamped scan range
// one multiply stage for the midpoint, one for the edge products and one for the sign
// tests and RAM write, and then the output step. An empty box goes to output straight
// from the box step and an empty scan range from the first midpoint step. Commands
// are handled one at a time.
// A result waits in the output register while the receiver stalls; the next
// command is accepted in the cycle after that result has been taken.
module triangle_sector_grid_locator_top
  import tsgl_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  parameter int ID_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  tsgl_in_if.sink    in_ch,
  tsgl_out_if.source out_ch,
  tsgl_cfg_if.sink   cfg_ch
);
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = ID_BITS + 1;
  localparam int WC = $clog2(DEPTH + 1);

  logic signed [23:0] org_x_r, org_y_r;
  logic [22:0] cw_r, ch_r;
  logic [23:0] inv_w_r, inv_h_r;
  logic [6:0] cols_cfg_r, rows_cfg_r;

  logic [CCW-1:0] cols_eff;
  logic [RCW-1:0] rows_eff;
  always_comb begin
    if (cols_cfg_r == 7'd0) cols_eff = CCW'(1);
    else if (32'(cols_cfg_r) > MAX_COLS) cols_eff = CCW'(MAX_COLS);
    else cols_eff = CCW'(cols_cfg_r);
    if (rows_cfg_r == 7'd0) rows_eff = RCW'(1);
    else if (32'(rows_cfg_r) > MAX_ROWS) rows_eff = RCW'(MAX_ROWS);
    else rows_eff = RCW'(rows_cfg_r);
  end
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;
  assign last_col = CW'(cols_eff - CCW'(1));
  assign last_row = RW'(rows_eff - RCW'(1));

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0;
      cw_r <= 23'd256; ch_r <= 23'd256;
      inv_w_r <= 24'd65536; inv_h_r <= 24'd65536;
      cols_cfg_r <= 7'd64; rows_cfg_r <= 7'd64;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_ORIGIN_X: org_x_r <= cfg_ch.data;
        REG_ORIGIN_Y: org_y_r <= cfg_ch.data;
        REG_CELL_W:   cw_r <= cfg_ch.data[22:0];
        REG_CELL_H:   ch_r <= cfg_ch.data[22:0];
        REG_INV_W:    inv_w_r <= cfg_ch.data;
        REG_INV_H:    inv_h_r <= cfg_ch.data;
        REG_COLS:     cols_cfg_r <= cfg_ch.data[6:0];
        REG_ROWS:     rows_cfg_r <= cfg_ch.data[6:0];
        default: ;
      endcase
    end
  end

  state_t st_r, st_nxt;
  logic boot_r;
  logic [AW-1:0] boot_addr_r;

  logic [1:0] mode_r;
  logic signed [25:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [ID_BITS-1:0] id_r;

  // Bounds in Q9; nonnegative after clamping, up to 27 bits.
  logic signed [27:0] nlx_r, nhx_r, nly_r, nhy_r;
  logic [51:0] c0p_r, c1p_r, r0p_r, r1p_r;
  logic [CW-1:0] c0_r, c1_r, col_r;
  logic [RW-1:0] row_r;
  logic [RW:0] r1_r;
  logic empty_r;
  logic signed [39:0] mx_r, my_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic [WC-1:0] cnt_r;
  logic [CW-1:0] clr_col_r;
  logic [RW-1:0] clr_row_r;

  logic signed [25:0] qdx_r, qdy_r;
  logic [49:0] qcp_r, qrp_r;
  logic [CW-1:0] qc_r;
  logic [RW-1:0] qr_r;

  logic o_valid_r, o_hit_r;
  logic [OUT_ID_W-1:0] o_id_r;
  logic [OUT_SEC_W-1:0] o_col_r, o_row_r;
  logic [OUT_CNT_W-1:0] o_cnt_r;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic in_fire;
  assign in_ch.ready = (st_r == ST_IDLE) && !boot_r && !o_valid_r;
  assign in_fire = in_ch.valid && in_ch.ready;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
    addr_of = AW'(r * MAX_COLS + c);
  endfunction

  logic signed [27:0] minx, maxx, miny, maxy, lx, hx, ly, hy;
  always_comb begin
    minx = 28'(ax_r); maxx = 28'(ax_r);
    if (28'(bx_r) < minx) minx = 28'(bx_r);
    if (28'(cx_r) < minx) minx = 28'(cx_r);
    if (28'(bx_r) > maxx) maxx = 28'(bx_r);
    if (28'(cx_r) > maxx) maxx = 28'(cx_r);
    miny = 28'(ay_r); maxy = 28'(ay_r);
    if (28'(by_r) < miny) miny = 28'(by_r);
    if (28'(cy_r) < miny) miny = 28'(cy_r);
    if (28'(by_r) > maxy) maxy = 28'(by_r);
    if (28'(cy_r) > maxy) maxy = 28'(cy_r);
    lx = minx - (28'(org_x_r) <<< 1) + 28'(cw_r);
    hx = maxx - (28'(org_x_r) <<< 1) - 28'(cw_r);
    ly = miny - (28'(org_y_r) <<< 1) + 28'(ch_r);
    hy = maxy - (28'(org_y_r) <<< 1) - 28'(ch_r);
  end

  logic edges_ok;
  assign edges_ok = (p0_r - p1_r >= 0) && (p2_r - p3_r >= 0) && (p4_r - p5_r >= 0);

  logic [CW:0] c1_full;
  logic [RW:0] r1_full;
  logic [CW:0] qc_full;
  logic [RW:0] qr_full;
  always_comb begin
    c1_full = (c1p_r[51:25] > 27'(last_col)) ? (CW+1)'(last_col) : (CW+1)'(c1p_r[51:25]);
    r1_full = (r1p_r[51:25] > 27'(last_row)) ? (RW+1)'(last_row) : (RW+1)'(r1p_r[51:25]);
    qc_full = (qcp_r[49:24] > 26'(last_col)) ? (CW+1)'(last_col) : (CW+1)'(qcp_r[49:24]);
    qr_full = (qrp_r[49:24] > 26'(last_row)) ? (RW+1)'(last_row) : (RW+1)'(qrp_r[49:24]);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (mode_t'(in_ch.mode))
            MODE_CLEAR:  st_nxt = ST_CLR;
            MODE_INSERT: st_nxt = ST_BOX;
            MODE_QUERY:  st_nxt = ST_Q_SCALE;
            default:     st_nxt = ST_OUT;
          endcase
        end
      end
      ST_CLR: begin
        if (clr_col_r == last_col && clr_row_r == last_row) st_nxt = ST_OUT;
      end
      ST_BOX: st_nxt = (hx >= 0 && hy >= 0) ? ST_SCALE : ST_OUT;
      ST_SCALE: st_nxt = ST_SCAN_SETUP;
      ST_SCAN_SETUP: st_nxt = ST_MID;
      ST_MID: st_nxt = empty_r ? ST_OUT : ST_EDGE;
      ST_EDGE: st_nxt = ST_TEST;
      ST_TEST: begin
        if (col_r == c1_r && {1'b0, row_r} == r1_r) st_nxt = ST_OUT;
        else st_nxt = ST_MID;
      end
      ST_Q_SCALE: st_nxt = ST_Q_READ;
      ST_Q_READ: st_nxt = ST_Q_DATA;
      ST_Q_DATA: st_nxt = ST_OUT;
      ST_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = addr_of(row_r, col_r);
    ram_wdata = {1'b1, id_r};
    ram_raddr = addr_of(qr_r, qc_r);
    if (boot_r) begin
      ram_we = 1'b1;
      ram_waddr = boot_addr_r;
      ram_wdata = '0;
    end else if (st_r == ST_CLR) begin
      ram_we = 1'b1;
      ram_waddr = addr_of(clr_row_r, clr_col_r);
      ram_wdata = '0;
    end else if (st_r == ST_TEST) begin
      ram_we = edges_ok;
    end
  end

  tsgl_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_grid (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      boot_r <= 1'b1;
      boot_addr_r <= '0;
      o_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (boot_r) begin
        boot_addr_r <= AW'(boot_addr_r + AW'(1));
        if (32'(boot_addr_r) == DEPTH - 1) boot_r <= 1'b0;
      end
      if (st_r == ST_OUT) o_valid_r <= 1'b1;
      else if (o_valid_r && out_ch.ready) o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        mode_r <= in_ch.mode;
        ax_r <= 26'(in_ch.vert_a_x) <<< 1; ay_r <= 26'(in_ch.vert_a_y) <<< 1;
        bx_r <= 26'(in_ch.vert_b_x) <<< 1; by_r <= 26'(in_ch.vert_b_y) <<< 1;
        cx_r <= 26'(in_ch.vert_c_x) <<< 1; cy_r <= 26'(in_ch.vert_c_y) <<< 1;
        id_r <= ID_BITS'(in_ch.triangle_id);
        qdx_r <= 26'(in_ch.point_x) - 26'(org_x_r);
        qdy_r <= 26'(in_ch.point_y) - 26'(org_y_r);
        cnt_r <= '0;
        clr_col_r <= '0;
        clr_row_r <= '0;
      end
      ST_CLR: begin
        cnt_r <= WC'(cnt_r + WC'(1));
        if (clr_col_r == last_col) begin
          clr_col_r <= '0;
          clr_row_r <= RW'(clr_row_r + RW'(1));
        end else begin
          clr_col_r <= CW'(clr_col_r + CW'(1));
        end
      end
      ST_BOX: begin
        nlx_r <= (lx < 0) ? '0 : lx;
        nhx_r <= hx;
        nly_r <= (ly < 0) ? '0 : ly;
        nhy_r <= hy;
      end
      ST_SCALE: begin
        c0p_r <= 52'(unsigned'(nlx_r)) * 52'(inv_w_r);
        c1p_r <= 52'(unsigned'(nhx_r)) * 52'(inv_w_r);
        r0p_r <= 52'(unsigned'(nly_r)) * 52'(inv_h_r);
        r1p_r <= 52'(unsigned'(nhy_r)) * 52'(inv_h_r);
      end
      ST_SCAN_SETUP: begin
        c1_r <= CW'(c1_full);
        r1_r <= r1_full;
        c0_r <= CW'(c0p_r[51:25]);
        col_r <= CW'(c0p_r[51:25]);
        row_r <= RW'(r0p_r[51:25]);
        empty_r <= (c0p_r[51:25] > 27'(c1_full)) || (r0p_r[51:25] > 27'(r1_full));
      end
      ST_MID: begin
        mx_r <= (40'(org_x_r) <<< 1) + 40'({col_r, 1'b1}) * 40'(cw_r);
        my_r <= (40'(org_y_r) <<< 1) + 40'({row_r, 1'b1}) * 40'(ch_r);
      end
      ST_EDGE: begin
        p0_r <= 64'(bx_r - ax_r) * 64'(my_r - 40'(ay_r));
        p1_r <= 64'(by_r - ay_r) * 64'(mx_r - 40'(ax_r));
        p2_r <= 64'(cx_r - bx_r) * 64'(my_r - 40'(by_r));
        p3_r <= 64'(cy_r - by_r) * 64'(mx_r - 40'(bx_r));
        p4_r <= 64'(ax_r - cx_r) * 64'(my_r - 40'(cy_r));
        p5_r <= 64'(ay_r - cy_r) * 64'(mx_r - 40'(cx_r));
      end
      ST_TEST: begin
        if (edges_ok) cnt_r <= WC'(cnt_r + WC'(1));
        if (col_r == c1_r) begin
          col_r <= c0_r;
          row_r <= RW'(row_r + RW'(1));
        end else begin
          col_r <= CW'(col_r + CW'(1));
        end
      end
      ST_Q_SCALE: begin
        qcp_r <= (qdx_r > 0) ? 50'(unsigned'(qdx_r)) * 50'(inv_w_r) : '0;
        qrp_r <= (qdy_r > 0) ? 50'(unsigned'(qdy_r)) * 50'(inv_h_r) : '0;
      end
      ST_Q_READ: begin
        qc_r <= CW'(qc_full);
        qr_r <= RW'(qr_full);
      end
      ST_OUT: begin
        o_hit_r <= 1'b0; o_id_r <= '0; o_col_r <= '0; o_row_r <= '0; o_cnt_r <= '0;
        case (mode_t'(mode_r))
          MODE_CLEAR, MODE_INSERT: o_cnt_r <= OUT_CNT_W'(cnt_r);
          MODE_QUERY: begin
            o_col_r <= OUT_SEC_W'(qc_r);
            o_row_r <= OUT_SEC_W'(qr_r);
            o_hit_r <= ram_rdata[EW-1];
            o_id_r <= ram_rdata[EW-1] ? OUT_ID_W'(ram_rdata[ID_BITS-1:0]) : '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign out_ch.valid = o_valid_r;
  assign out_ch.hit_valid = o_hit_r;
  assign out_ch.found_id = o_id_r;
  assign out_ch.sector_col = o_col_r;
  assign out_ch.sector_row = o_row_r;
  assign out_ch.cells_written = o_cnt_r;
endmodule

// ----- hw/rtl/tsgl_checker.sv -----
module tsgl_checker
  import tsgl_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit_valid,
  input logic [OUT_ID_W-1:0] out_found_id,
  input logic [OUT_CNT_W-1:0] out_cells_written
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found_id))
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("command accepted while result pending");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit_valid |-> out_found_id == '0)
    else $error("identifier without hit");
  a_hit_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit_valid |-> out_cells_written == '0)
    else $error("query reported written cells");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result appeared too early");
endmodule

bind triangle_sector_grid_locator_top tsgl_checker u_tsgl_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_hit_valid(out_ch.hit_valid), .out_found_id(out_ch.found_id),
  .out_cells_written(out_ch.cells_written)
);
